[rtl/hse_pkg.sv]
// shared types and sizing constants for the heap sort engine
package hse_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  // child indexes reach 2 * MAX_ITEMS
  localparam int CHILD_W   = ADDR_W + 2;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } hse_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_set;
    logic                     overflow;
  } hse_out_t;

endpackage

[rtl/heap_sort_engine.sv]
// heap sort engine: buffers a set of signed values, heap-sorts it in memory, streams it out
//
//   channel | signals                          | item
//   --------+----------------------------------+-----------------------------------------
//   in      | in_valid, in_ready, in_data      | value, last
//   out     | out_valid, out_ready, out_data   | sorted_value, end_of_set, overflow
//   cfg     | cfg_valid, cfg_ready, cfg_data   | direction (0 increasing, 1 decreasing)
//
// loading accepts one item per cycle; in_ready is high only while loading.
// the heap lives in one 64-entry memory with two registered read ports; each sift-down
// of the build first fetches its node as the carried value; every sift-down then compares
// once per heap level it visits. the output register frees the sift of the next result
// from a stalled consumer. rst is synchronous; it empties the buffer, clears overflow and
// direction.
module heap_sort_engine import hse_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  hse_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output hse_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_FETCH,
    S_CARRY,
    S_CMP,
    S_ROOT,
    S_TAKE
  } state_t;

  state_t state;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  size;
  logic              dropped;
  logic              direction;
  logic              building;
  logic [ADDR_W-1:0] node;
  logic [ADDR_W-1:0] build_node;
  logic signed [DATA_W-1:0] carry;

  logic signed [DATA_W-1:0] mem [MAX_ITEMS];
  logic signed [DATA_W-1:0] rd_a;
  logic signed [DATA_W-1:0] rd_b;
  logic [ADDR_W-1:0]        addr_a;
  logic [ADDR_W-1:0]        addr_b;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;

  logic                     room;
  logic [CHILD_W-1:0]       left_idx;
  logic [CHILD_W-1:0]       right_idx;
  logic                     left_ok;
  logic                     right_ok;
  logic                     right_wins;
  logic signed [DATA_W-1:0] child_val;
  logic [CHILD_W-1:0]       best_idx;
  logic [ADDR_W-1:0]        best_node;
  logic [CHILD_W-1:0]       best_left;
  logic [CHILD_W-1:0]       best_right;
  logic                     promote;

  // the root is the next item to emit: min-heap for increasing, max-heap for decreasing
  function automatic logic above(input logic signed [DATA_W-1:0] a,
                                 input logic signed [DATA_W-1:0] b,
                                 input logic dir);
    above = dir ? (a > b) : (a < b);
  endfunction

  assign in_ready  = (state == S_LOAD);
  assign cfg_ready = 1'b1;

  assign room       = (count < CNT_W'(MAX_ITEMS));
  assign count_next = room ? count + CNT_W'(1) : count;

  assign left_idx   = {1'b0, node, 1'b1};
  assign right_idx  = {1'b0, node, 1'b0} + CHILD_W'(2);
  assign left_ok    = (left_idx < CHILD_W'(size));
  assign right_ok   = (right_idx < CHILD_W'(size));
  assign right_wins = right_ok && above(rd_b, rd_a, direction);
  assign child_val  = right_wins ? rd_b : rd_a;
  assign best_idx   = right_wins ? right_idx : left_idx;
  assign best_node  = best_idx[ADDR_W-1:0];
  assign best_left  = {1'b0, best_node, 1'b1};
  assign best_right = {1'b0, best_node, 1'b0} + CHILD_W'(2);
  assign promote    = left_ok && above(child_val, carry, direction);

  // read addresses; child addresses past the heap read don't-care data that is never used
  always_comb begin
    unique case (state)
      S_FETCH: begin
        addr_a = build_node;
        addr_b = build_node;
      end
      S_CARRY: begin
        addr_a = left_idx[ADDR_W-1:0];
        addr_b = right_idx[ADDR_W-1:0];
      end
      S_CMP: begin
        addr_a = best_left[ADDR_W-1:0];
        addr_b = best_right[ADDR_W-1:0];
      end
      S_ROOT: begin
        addr_a = '0;
        addr_b = ADDR_W'(size - CNT_W'(1));
      end
      S_TAKE: begin
        addr_a = ADDR_W'(1);
        addr_b = ADDR_W'(2);
      end
      default: begin
        addr_a = '0;
        addr_b = '0;
      end
    endcase
  end

  always_comb begin
    unique case (state)
      S_LOAD: begin
        mem_we    = in_valid && room;
        mem_waddr = count[ADDR_W-1:0];
        mem_wdata = in_data.value;
      end
      S_CMP: begin
        // hole walk: move the better child up, or drop the carried value in
        mem_we    = 1'b1;
        mem_waddr = node;
        mem_wdata = promote ? child_val : carry;
      end
      default: begin
        mem_we    = 1'b0;
        mem_waddr = node;
        mem_wdata = carry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      dropped   <= 1'b0;
      direction <= 1'b0;
      building  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        direction <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            count <= count_next;
            if (!room) begin
              dropped <= 1'b1;
            end
            if (in_data.last) begin
              size  <= count_next;
              state <= S_START;
            end
          end
        end
        S_START: begin
          if (size >= CNT_W'(2)) begin
            build_node <= ADDR_W'((size >> 1) - CNT_W'(1));
            building   <= 1'b1;
            state      <= S_FETCH;
          end else begin
            building <= 1'b0;
            state    <= S_ROOT;
          end
        end
        S_FETCH: begin
          node  <= build_node;
          state <= S_CARRY;
        end
        S_CARRY: begin
          carry <= rd_a;
          state <= S_CMP;
        end
        S_CMP: begin
          if (promote) begin
            node <= best_node;
          end else if (building) begin
            if (build_node == '0) begin
              building <= 1'b0;
              state    <= S_ROOT;
            end else begin
              build_node <= build_node - ADDR_W'(1);
              state      <= S_FETCH;
            end
          end else begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          // wait until the output register is free at the next edge
          if (!out_valid || out_ready) begin
            state <= S_TAKE;
          end
        end
        S_TAKE: begin
          out_data.sorted_value <= rd_a;
          out_data.end_of_set   <= (size == CNT_W'(1));
          out_data.overflow     <= dropped;
          out_valid             <= 1'b1;
          // last heap entry becomes the carried value sifted from the root
          carry <= rd_b;
          size  <= size - CNT_W'(1);
          node  <= '0;
          if (size == CNT_W'(1)) begin
            count   <= '0;
            dropped <= 1'b0;
            state   <= S_LOAD;
          end else begin
            state <= S_CMP;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

[test/heap_sort_checker.sv]
`timescale 1ns / 100ps
// prediction of sorted sets and comparison of every output item for the heap sort engine
module heap_sort_checker import hse_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_ready,
  input  hse_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  hse_out_t out_data,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  logic     cfg_data,
  output int       mismatches,
  output int       pending
);

  logic signed [DATA_W-1:0] heap_mem [MAX_ITEMS];
  int       stored;
  logic     dropped;
  logic     descending;
  hse_out_t sorted_q [$];

  // max-heap for increasing order, min-heap for decreasing order
  function automatic bit ranks_above(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b);
    return descending ? (a < b) : (a > b);
  endfunction

  function automatic void sift_down(input int heap_len, input int node);
    int                       best;
    int                       kid;
    logic signed [DATA_W-1:0] tmp;
    forever begin
      best = node;
      kid  = 2 * node + 1;
      if (kid < heap_len && ranks_above(heap_mem[kid], heap_mem[best])) best = kid;
      kid = kid + 1;
      if (kid < heap_len && ranks_above(heap_mem[kid], heap_mem[best])) best = kid;
      if (best == node) return;
      tmp            = heap_mem[node];
      heap_mem[node] = heap_mem[best];
      heap_mem[best] = tmp;
      node           = best;
    end
  endfunction

  function automatic void heap_sort(input int n);
    logic signed [DATA_W-1:0] tmp;
    for (int i = n / 2; i > 0; i--) sift_down(n, i - 1);
    for (int i = n; i > 1; i--) begin
      tmp             = heap_mem[0];
      heap_mem[0]     = heap_mem[i - 1];
      heap_mem[i - 1] = tmp;
      sift_down(i - 1, 0);
    end
  endfunction

  // store or drop one value; the last item sorts the set and queues its results
  function automatic void load_value(input hse_in_t item);
    hse_out_t res;
    if (stored < MAX_ITEMS) begin
      heap_mem[stored] = item.value;
      stored++;
    end else begin
      dropped = 1'b1;
    end
    if (!item.last) return;
    heap_sort(stored);
    for (int k = 0; k < stored; k++) begin
      res.sorted_value = heap_mem[k];
      res.end_of_set   = (k == stored - 1);
      res.overflow     = dropped;
      sorted_q.push_back(res);
    end
    stored  = 0;
    dropped = 1'b0;
  endfunction

  always @(posedge clk) begin
    hse_out_t want;
    if (rst) begin
      stored     = 0;
      dropped    = 1'b0;
      descending = 1'b0;
      sorted_q.delete();
      mismatches <= 0;
    end else begin
      if (cfg_valid && cfg_ready) descending = cfg_data;
      if (in_valid && in_ready) load_value(in_data);
      if (out_valid && out_ready) begin
        if (sorted_q.size() == 0) begin
          mismatches <= mismatches + 1;
          $display("%0t: unexpected item: value %0d end %0b overflow %0b", $time,
                   out_data.sorted_value, out_data.end_of_set, out_data.overflow);
        end else begin
          want = sorted_q.pop_front();
          if (out_data !== want) begin
            mismatches <= mismatches + 1;
            $display("%0t: expected value %0d end %0b overflow %0b, got value %0d end %0b overflow %0b",
                     $time, want.sorted_value, want.end_of_set, want.overflow,
                     out_data.sorted_value, out_data.end_of_set, out_data.overflow);
          end
        end
      end
    end
    pending <= sorted_q.size();
  end

endmodule

[test/heap_sort_engine_test.sv]
`timescale 1ns / 100ps
// stimulus, flow control and verdict for the heap sort engine
module heap_sort_engine_test;
  import hse_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 600;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 16;
  localparam int SETTLE_CYCLES = 20;
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  hse_in_t  in_data   = '0;
  logic     out_ready = 1'b0;
  logic     cfg_valid = 1'b0;
  logic     cfg_data  = 1'b0;
  logic     in_ready;
  logic     out_valid;
  hse_out_t out_data;
  logic     cfg_ready;

  logic hold_req  = 1'b0;
  int   hold_left = 0;
  int   recv_idle = 0;
  int   send_idle = 0;
  int   quiet     = 0;
  int   mismatches;
  int   pending;
  logic signed [DATA_W-1:0] prev_value = '0;

  always #5 clk = ~clk;

  heap_sort_engine u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  heap_sort_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // consumer: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // end the run when no channel moves an item for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_value(input logic signed [DATA_W-1:0] v, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= hse_in_t'{value: v, last: last};
    do @(posedge clk); while (!in_ready);
  endtask

  // extremes, small values and repeats mixed into fully random words
  task automatic send_set(input int set_len);
    logic signed [DATA_W-1:0] v;
    for (int k = 0; k < set_len; k++) begin
      case ($urandom_range(9))
        0:       v = VAL_MIN;
        1:       v = VAL_MAX;
        2:       v = int'($urandom_range(8)) - 4;
        3:       v = prev_value;
        default: v = $urandom;
      endcase
      prev_value = v;
      push_value(v, k == set_len - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(input logic descending);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= descending;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int sent;
    int set_len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // single item, extremes and equal values in increasing order (reset direction)
    push_value(VAL_MIN, 1'b1);
    push_value(VAL_MAX, 1'b0);
    push_value(VAL_MIN, 1'b0);
    push_value(0, 1'b0);
    push_value(-1, 1'b0);
    push_value(1, 1'b0);
    push_value(VAL_MAX, 1'b0);
    push_value(VAL_MIN, 1'b1);
    push_value(5, 1'b0);
    push_value(5, 1'b0);
    push_value(5, 1'b0);
    push_value(-5, 1'b1);

    // same kinds of sets in decreasing order
    write_direction(1'b1);
    push_value(1, 1'b0);
    push_value(-1, 1'b0);
    push_value(0, 1'b0);
    push_value(VAL_MIN, 1'b0);
    push_value(VAL_MAX, 1'b1);
    push_value(VAL_MAX, 1'b1);
    push_value(7, 1'b0);
    push_value(7, 1'b0);
    push_value(-7, 1'b0);
    push_value(7, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      write_direction(1'(ph % 2));
      case (ph % 4)
        0: begin send_idle = 0;  recv_idle <= 0;  end
        1: begin send_idle = 63; recv_idle <= 0;  end
        2: begin send_idle = 0;  recv_idle <= 63; end
        default: begin send_idle = 6; recv_idle <= 6; end
      endcase
      // long consumer hold-off: output backs up and the input stalls
      if (ph == 6) begin
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      sent = 0;
      // exactly full buffer, then overflow in both directions
      if (ph == 1 || ph == 4 || ph == 7) begin
        set_len = (ph == 1) ? MAX_ITEMS : (ph == 4) ? MAX_ITEMS + 2 : MAX_ITEMS + 5;
        send_set(set_len);
        sent += set_len;
      end
      while (sent < PHASE_ITEMS) begin
        set_len = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        send_set(set_len);
        sent += set_len;
      end
    end

    wait_drained();
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
